// ===== hw/rtl/dtwl1_pkg.sv =====
// shared constants and controller/datapath interface types for the dtw l1 matcher
package dtwl1_pkg;

    localparam int MAX_TEMPLATE_FRAMES_DEF = 256;
    localparam int MAX_COEFS_DEF           = 32;
    localparam int COEF_WIDTH_DEF          = 16;
    localparam int COST_WIDTH_DEF          = 40;

    localparam int CFG_WIDTH    = 6;
    localparam int STATUS_WIDTH = 2;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 2;

    localparam logic KIND_TEMPLATE = 1'b0;
    localparam logic KIND_SAMPLE   = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_SHORT    = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic take;
        logic issue;
        logic upd1;
        logic upd2;
        logic emit;
    } dtwl1_cmd_t;

    typedef struct packed {
        logic match_req;
        logic result_req;
        logic row_empty;
        logic last_k;
        logic last_j;
        logic out_free;
    } dtwl1_status_t;

endpackage

// ===== hw/rtl/dtwl1_ctrl.sv =====
// sequencing state machine for item intake, row matching and result transfer
module dtwl1_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  dtwl1_pkg::dtwl1_status_t st,
    output dtwl1_pkg::dtwl1_cmd_t    cmd
);
    import dtwl1_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIST  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_UPD1  = 6'b001000,
        S_UPD2  = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   pend_last_reg, pend_last_next;

    always_comb begin
        state_next     = state_reg;
        pend_last_next = pend_last_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid) begin
                    if (st.match_req && !st.row_empty) begin
                        state_next     = S_DIST;
                        pend_last_next = st.result_req;
                    end else if (st.result_req) begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_DIST: begin
                cmd.issue = 1'b1;
                if (st.last_k) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_UPD1;
            end
            S_UPD1: begin
                cmd.upd1   = 1'b1;
                state_next = S_UPD2;
            end
            S_UPD2: begin
                cmd.upd2 = 1'b1;
                if (!st.last_j) begin
                    state_next = S_DIST;
                end else if (pend_last_reg) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                cmd.emit = st.out_free;
                if (st.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pend_last_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_last_reg <= pend_last_next;
        end
    end

endmodule

// ===== hw/rtl/dtwl1_datapath.sv =====
// template and sample storage, frame distance accumulator and cost row update
module dtwl1_datapath #(
    parameter int MAX_TEMPLATE_FRAMES = dtwl1_pkg::MAX_TEMPLATE_FRAMES_DEF,
    parameter int MAX_COEFS           = dtwl1_pkg::MAX_COEFS_DEF,
    parameter int COEF_WIDTH          = dtwl1_pkg::COEF_WIDTH_DEF,
    parameter int COST_WIDTH          = dtwl1_pkg::COST_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [dtwl1_pkg::CFG_WIDTH-1:0]       cfg_cpf,
    input  dtwl1_pkg::dtwl1_cmd_t                 cmd,
    output dtwl1_pkg::dtwl1_status_t              st,
    input  logic                                  s_kind,
    input  logic signed [COEF_WIDTH-1:0]          s_coef,
    input  logic                                  s_last,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic [COST_WIDTH-1:0]                 m_total_cost,
    output logic [dtwl1_pkg::STATUS_WIDTH-1:0]    m_status,
    output logic                                  m_saturated
);
    import dtwl1_pkg::*;

    localparam int CC_W   = $clog2(MAX_COEFS + 1);
    localparam int KI_W   = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
    localparam int FR_W   = $clog2(MAX_TEMPLATE_FRAMES + 1);
    localparam int FI_W   = (MAX_TEMPLATE_FRAMES > 1) ? $clog2(MAX_TEMPLATE_FRAMES) : 1;
    localparam int TDEPTH = MAX_TEMPLATE_FRAMES * MAX_COEFS;
    localparam int TA_W   = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int DIF_W  = COEF_WIDTH + 1;
    localparam int ACC_W  = DIF_W + CC_W;
    localparam int EXT_W  = (ACC_W > COST_WIDTH) ? ACC_W : COST_WIDTH;
    localparam logic [COST_WIDTH-1:0] COST_MAX = {COST_WIDTH{1'b1}};

    logic [COEF_WIDTH-1:0] tmpl_mem [TDEPTH];
    logic [COEF_WIDTH-1:0] buf_mem  [MAX_COEFS];
    logic [COST_WIDTH-1:0] cost_mem [MAX_TEMPLATE_FRAMES];

    logic            loading_reg, loading_next;
    logic            ovf_reg, ovf_next;
    logic            first_row_reg, first_row_next;
    logic            sat_reg, sat_next;
    logic            pend_tmpl_reg, pend_tmpl_next;
    logic            rd_vld_reg;
    logic            m_valid_reg, m_valid_next;
    logic [CC_W-1:0] cc_reg, cc_next;
    logic [FR_W-1:0] frames_reg, frames_next;
    logic [FI_W-1:0] j_reg, j_next;
    logic [KI_W-1:0] k_reg, k_next;

    logic [COEF_WIDTH-1:0] tmpl_rd_reg, buf_rd_reg;
    logic [COST_WIDTH-1:0] up_reg, left_reg, diag_reg, d_reg, a_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [COST_WIDTH-1:0] m_total_reg;
    logic [STATUS_WIDTH-1:0] m_status_reg;
    logic                  m_sat_reg;

    logic [CC_W-1:0] eff_n, cc_cur, cc_inc;
    logic [FR_W-1:0] frames_cur;
    logic            restart, room, frame_full, tmpl_we, buf_we, has_room_frame;
    logic [TA_W-1:0] tmpl_waddr, tmpl_raddr;
    logic signed [DIF_W-1:0] diff;
    logic [DIF_W-1:0] absd;
    logic [EXT_W-1:0] acc_ext;
    logic             acc_over;
    logic [COST_WIDTH-1:0] d_clamp, m_lu, m_min, a_sel, cell_cost;
    logic [COST_WIDTH:0]   sum;
    logic             sample_bad;

    always_comb begin
        if (cfg_cpf == '0) begin
            eff_n = CC_W'(1);
        end else if (32'(cfg_cpf) > MAX_COEFS) begin
            eff_n = CC_W'(MAX_COEFS);
        end else begin
            eff_n = CC_W'(cfg_cpf);
        end
    end

    assign restart        = (s_kind == KIND_TEMPLATE) && !loading_reg;
    assign cc_cur         = restart ? '0 : cc_reg;
    assign frames_cur     = restart ? '0 : frames_reg;
    assign room           = cc_cur < CC_W'(MAX_COEFS);
    assign cc_inc         = room ? cc_cur + CC_W'(1) : cc_cur;
    assign frame_full     = cc_inc >= eff_n;
    assign has_room_frame = 32'(frames_cur) < MAX_TEMPLATE_FRAMES;
    assign tmpl_we        = cmd.take && (s_kind == KIND_TEMPLATE) && has_room_frame && room;
    assign buf_we         = cmd.take && (s_kind == KIND_SAMPLE) && !loading_reg && room;
    assign tmpl_waddr     = TA_W'(frames_cur * MAX_COEFS + cc_cur);
    assign tmpl_raddr     = TA_W'(j_reg * MAX_COEFS + k_reg);

    assign st.match_req  = (s_kind == KIND_SAMPLE) && !loading_reg && frame_full;
    assign st.result_req = s_last && ((s_kind == KIND_TEMPLATE) || !loading_reg);
    assign st.row_empty  = (frames_reg == '0);
    assign st.last_k     = (CC_W'(k_reg) + CC_W'(1)) >= eff_n;
    assign st.last_j     = (FR_W'(j_reg) + FR_W'(1)) >= frames_reg;
    assign st.out_free   = !m_valid_reg || m_ready;

    assign diff    = $signed({tmpl_rd_reg[COEF_WIDTH-1], tmpl_rd_reg})
                   - $signed({buf_rd_reg[COEF_WIDTH-1], buf_rd_reg});
    assign absd    = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);
    assign acc_ext = EXT_W'(acc_reg);
    assign acc_over = acc_ext > EXT_W'(COST_MAX);
    assign d_clamp = acc_over ? COST_MAX : COST_WIDTH'(acc_reg);
    assign m_lu    = (left_reg < up_reg) ? left_reg : up_reg;
    assign m_min   = (diag_reg < m_lu) ? diag_reg : m_lu;

    always_comb begin
        if (first_row_reg) begin
            a_sel = (j_reg == '0) ? '0 : left_reg;
        end else begin
            a_sel = (j_reg == '0) ? up_reg : m_min;
        end
    end

    assign sum       = {1'b0, a_reg} + {1'b0, d_reg};
    assign cell_cost = sum[COST_WIDTH] ? COST_MAX : sum[COST_WIDTH-1:0];
    assign sample_bad = (cc_reg != '0) || first_row_reg || (frames_reg == '0);

    always_comb begin
        loading_next   = loading_reg;
        ovf_next       = ovf_reg;
        first_row_next = first_row_reg;
        sat_next       = sat_reg;
        pend_tmpl_next = pend_tmpl_reg;
        m_valid_next   = m_valid_reg;
        cc_next        = cc_reg;
        frames_next    = frames_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.take) begin
            j_next = '0;
            k_next = '0;
            if (s_kind == KIND_TEMPLATE) begin
                loading_next   = 1'b1;
                pend_tmpl_next = 1'b1;
                ovf_next       = (restart ? 1'b0 : ovf_reg) | !has_room_frame;
                cc_next        = cc_cur;
                frames_next    = frames_cur;
                if (has_room_frame && room) begin
                    cc_next = frame_full ? '0 : cc_inc;
                    if (frame_full) begin
                        frames_next = frames_cur + FR_W'(1);
                    end
                end
            end else if (!loading_reg) begin
                pend_tmpl_next = 1'b0;
                cc_next        = frame_full ? '0 : cc_inc;
                if (frame_full && (frames_reg == '0)) begin
                    first_row_next = 1'b0;
                end
            end
        end
        if (cmd.issue) begin
            k_next = st.last_k ? '0 : k_reg + KI_W'(1);
        end
        if (cmd.upd1 && acc_over) begin
            sat_next = 1'b1;
        end
        if (cmd.upd2) begin
            j_next = j_reg + FI_W'(1);
            if (sum[COST_WIDTH]) begin
                sat_next = 1'b1;
            end
            if (st.last_j) begin
                first_row_next = 1'b0;
            end
        end
        if (cmd.emit) begin
            m_valid_next   = 1'b1;
            cc_next        = '0;
            first_row_next = 1'b1;
            sat_next       = 1'b0;
            if (pend_tmpl_reg) begin
                loading_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loading_reg   <= 1'b1;
            ovf_reg       <= 1'b0;
            first_row_reg <= 1'b1;
            sat_reg       <= 1'b0;
            pend_tmpl_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            cc_reg        <= '0;
            frames_reg    <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end else begin
            loading_reg   <= loading_next;
            ovf_reg       <= ovf_next;
            first_row_reg <= first_row_next;
            sat_reg       <= sat_next;
            pend_tmpl_reg <= pend_tmpl_next;
            rd_vld_reg    <= cmd.issue;
            m_valid_reg   <= m_valid_next;
            cc_reg        <= cc_next;
            frames_reg    <= frames_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tmpl_we) begin
            tmpl_mem[tmpl_waddr] <= s_coef;
        end
        if (cmd.issue) begin
            tmpl_rd_reg <= tmpl_mem[tmpl_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[cc_cur[KI_W-1:0]] <= s_coef;
        end
        if (cmd.issue) begin
            buf_rd_reg <= buf_mem[k_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd2) begin
            cost_mem[j_reg] <= cell_cost;
        end
        if (cmd.issue && (k_reg == '0)) begin
            up_reg <= cost_mem[j_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue && (k_reg == '0)) begin
            acc_reg <= '0;
        end else if (rd_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(absd);
        end
        if (cmd.upd1) begin
            d_reg <= d_clamp;
            a_reg <= a_sel;
        end
        if (cmd.upd2) begin
            left_reg <= cell_cost;
            if (!first_row_reg) begin
                diag_reg <= up_reg;
            end
        end
        if (cmd.emit) begin
            if (pend_tmpl_reg) begin
                m_total_reg  <= '0;
                m_sat_reg    <= 1'b0;
                m_status_reg <= ovf_reg ? ST_OVERFLOW
                              : (((cc_reg != '0) || (frames_reg == '0)) ? ST_SHORT : ST_OK);
            end else begin
                m_total_reg  <= sample_bad ? '0 : left_reg;
                m_sat_reg    <= sat_reg;
                m_status_reg <= ovf_reg ? ST_OVERFLOW : (sample_bad ? ST_SHORT : ST_OK);
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_total_cost = m_total_reg;
    assign m_status     = m_status_reg;
    assign m_saturated  = m_sat_reg;

`ifndef SYNTH
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending transfer");
    a_frames_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(frames_reg) <= MAX_TEMPLATE_FRAMES)
        else $error("template frame count beyond capacity");
    a_issue_ctx: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (!loading_reg && (frames_reg != '0)))
        else $error("row walk without a loaded template");
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.issue && st.last_k) |=> (rd_vld_reg && !cmd.issue))
        else $error("last coefficient read not drained");
`endif

endmodule

// ===== hw/rtl/dtw_l1_sequence_match.sv =====
// top level of the dtw l1 sequence matcher with apb configuration
//
// channel   handshake          payload
// s_        s_valid/s_ready    s_kind, s_coef, s_last
// m_        m_valid/m_ready    m_total_cost, m_status, m_saturated
// apb       psel/penable       paddr, pwdata, prdata (coefs_per_frame at 0)
//
// a template or sample coefficient that completes no sample frame and ends no sequence is taken in the idle state
// a completed sample frame walks all stored template frames, each in states dist, drain, upd1, upd2,
// with n coefficients per frame read from the template memory one per cycle in dist
// a result is loaded in the emit state and waits there while an earlier one is held and m_ready is low
// reset is synchronous and active low; memories are not cleared
module dtw_l1_sequence_match #(
    parameter int MAX_TEMPLATE_FRAMES = dtwl1_pkg::MAX_TEMPLATE_FRAMES_DEF,
    parameter int MAX_COEFS           = dtwl1_pkg::MAX_COEFS_DEF,
    parameter int COEF_WIDTH          = dtwl1_pkg::COEF_WIDTH_DEF,
    parameter int COST_WIDTH          = dtwl1_pkg::COST_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dtwl1_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dtwl1_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dtwl1_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic signed [COEF_WIDTH-1:0]         s_coef,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [COST_WIDTH-1:0]                m_total_cost,
    output logic [dtwl1_pkg::STATUS_WIDTH-1:0]   m_status,
    output logic                                 m_saturated
);
    import dtwl1_pkg::*;

    logic [CFG_WIDTH-1:0] cpf_reg, cpf_next;
    logic                 cfg_we;
    dtwl1_cmd_t           cmd;
    dtwl1_status_t        st;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr == '0);
    assign cpf_next = cfg_we ? pwdata[CFG_WIDTH-1:0] : cpf_reg;
    assign prdata = APB_DATA_W'(cpf_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpf_reg <= CFG_WIDTH'(1);
        end else begin
            cpf_reg <= cpf_next;
        end
    end

    dtwl1_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    dtwl1_datapath #(
        .MAX_TEMPLATE_FRAMES (MAX_TEMPLATE_FRAMES),
        .MAX_COEFS           (MAX_COEFS),
        .COEF_WIDTH          (COEF_WIDTH),
        .COST_WIDTH          (COST_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_cpf      (cpf_reg),
        .cmd          (cmd),
        .st           (st),
        .s_kind       (s_kind),
        .s_coef       (s_coef),
        .s_last       (s_last),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_total_cost (m_total_cost),
        .m_status     (m_status),
        .m_saturated  (m_saturated)
    );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the dtw l1 sequence matcher: predictor, driver, monitor
`timescale 1ns / 100ps

module testbench;
    import dtwl1_pkg::*;

    localparam int MAXF = MAX_TEMPLATE_FRAMES_DEF;
    localparam int MAXC = MAX_COEFS_DEF;
    localparam int CW = COEF_WIDTH_DEF;
    localparam int KW = COST_WIDTH_DEF;
    localparam logic [KW-1:0] COST_TOP = '1;
    localparam logic [APB_ADDR_W-1:0] ADDR_COEFS_PER_FRAME = '0;
    localparam int STALL_LIMIT = 40000;
    localparam int ITEM_TARGET = 650;

    typedef struct packed {
        logic kind;
        logic [CW-1:0] coef;
        logic last;
    } coef_xfer_t;

    typedef struct packed {
        logic [KW-1:0] cost;
        logic [STATUS_WIDTH-1:0] status;
        logic sat;
    } match_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_kind = 1'b0;
    logic signed [CW-1:0] s_coef = '0;
    logic s_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [KW-1:0] m_total_cost;
    logic [STATUS_WIDTH-1:0] m_status;
    logic m_saturated;

    dtw_l1_sequence_match u_top (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // matcher state mirror
    logic [CW-1:0] tmpl_mem [0:MAXF*MAXC-1];
    logic [CW-1:0] frame_buf [0:MAXC-1];
    logic [KW-1:0] row_cost [0:MAXF-1];
    int tmpl_frames = 0;
    int coef_cnt = 0;
    int unsigned row_cnt = 0;
    bit loading = 1'b1;
    bit sat_seen = 1'b0;
    bit tmpl_ovf = 1'b0;
    int cpf_reg = 1;

    coef_xfer_t pending_coefs[$];
    match_result_t expected_results[$];
    int mismatches = 0;
    int results_seen = 0;
    int coefs_taken = 0;
    int coefs_queued = 0;
    int idle_cycles = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int gap_left = 0;
    bit calm = 1'b0;
    int status_hits [0:3];

    function automatic int frame_len();
        if (cpf_reg == 0) return 1;
        if (cpf_reg > MAXC) return MAXC;
        return cpf_reg;
    endfunction

    function automatic logic [KW-1:0] add_clamp(logic [KW-1:0] a, logic [KW-1:0] b);
        logic [KW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[KW]) begin
            sat_seen = 1'b1;
            return COST_TOP;
        end
        return s[KW-1:0];
    endfunction

    function automatic logic [KW-1:0] l1_distance(int frame);
        longint sum;
        longint d;
        sum = 0;
        for (int k = 0; k < frame_len(); k++) begin
            d = longint'($signed(tmpl_mem[frame*MAXC+k])) - longint'($signed(frame_buf[k]));
            sum += (d < 0) ? -d : d;
        end
        if (sum > longint'(COST_TOP)) begin
            sat_seen = 1'b1;
            return COST_TOP;
        end
        return sum[KW-1:0];
    endfunction

    function automatic void update_cost_row();
        logic [KW-1:0] left, diag, up, d, c, m;
        left = '0;
        diag = '0;
        for (int j = 0; j < tmpl_frames && j < MAXF; j++) begin
            d = l1_distance(j);
            if (row_cnt == 0) begin
                c = (j == 0) ? d : add_clamp(left, d);
            end else begin
                up = row_cost[j];
                if (j == 0) begin
                    c = add_clamp(up, d);
                end else begin
                    m = (left < up) ? left : up;
                    if (diag < m) m = diag;
                    c = add_clamp(m, d);
                end
                diag = up;
            end
            row_cost[j] = c;
            left = c;
        end
        if (row_cnt != 32'hffff_ffff) row_cnt++;
    endfunction

    function automatic void predict_transfer(coef_xfer_t x);
        match_result_t r;
        int idx;
        if (x.kind == KIND_TEMPLATE) begin
            if (!loading) begin
                loading = 1'b1;
                tmpl_frames = 0;
                tmpl_ovf = 1'b0;
                coef_cnt = 0;
            end
            if (tmpl_frames >= MAXF) begin
                tmpl_ovf = 1'b1;
            end else if (coef_cnt < MAXC) begin
                tmpl_mem[tmpl_frames*MAXC+coef_cnt] = x.coef;
                coef_cnt++;
                if (coef_cnt >= frame_len()) begin
                    coef_cnt = 0;
                    tmpl_frames++;
                end
            end
            if (!x.last) return;
            r.cost = '0;
            r.sat = 1'b0;
            r.status = tmpl_ovf ? ST_OVERFLOW
                     : ((coef_cnt != 0 || tmpl_frames == 0) ? ST_SHORT : ST_OK);
            loading = 1'b0;
        end else begin
            if (loading) return;
            if (coef_cnt < MAXC) begin
                frame_buf[coef_cnt] = x.coef;
                coef_cnt++;
            end
            if (coef_cnt >= frame_len()) begin
                coef_cnt = 0;
                update_cost_row();
            end
            if (!x.last) return;
            r.cost = '0;
            if (coef_cnt != 0 || row_cnt == 0 || tmpl_frames == 0) begin
                r.status = tmpl_ovf ? ST_OVERFLOW : ST_SHORT;
            end else begin
                idx = (tmpl_frames - 1 >= MAXF) ? MAXF - 1 : tmpl_frames - 1;
                r.cost = row_cost[idx];
                r.status = tmpl_ovf ? ST_OVERFLOW : ST_OK;
            end
            r.sat = sat_seen;
        end
        coef_cnt = 0;
        row_cnt = 0;
        sat_seen = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic int pick_gap();
        int p;
        if (calm) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (!s_valid || s_ready) begin
                if (s_valid) begin
                    predict_transfer('{s_kind, s_coef, s_last});
                    coefs_taken++;
                end
                if ($urandom_range(0, 49) == 0) calm = !calm;
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_coefs.size() > 0) begin
                    coef_xfer_t x;
                    x = pending_coefs.pop_front();
                    s_kind <= x.kind;
                    s_coef <= x.coef;
                    s_last <= x.last;
                    s_valid <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and result check
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer cost=%0d status=%0d sat=%0b",
                                 m_total_cost, m_status, m_saturated);
                end else begin
                    match_result_t e;
                    e = expected_results.pop_front();
                    status_hits[e.status]++;
                    if (m_total_cost !== e.cost || m_status !== e.status
                        || m_saturated !== e.sat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected cost=%0d status=%0d sat=%0b, got cost=%0d status=%0d sat=%0b",
                                     results_seen, e.cost, e.status, e.sat,
                                     m_total_cost, m_status, m_saturated);
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                int p;
                p = $urandom_range(0, 99);
                m_ready <= (p < 70) ? 1'b1 : (p < 97) ? 1'b0 : ($urandom_range(0, 3) == 0);
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic logic [CW-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic push_coef(logic kind, logic [CW-1:0] c, logic last);
        pending_coefs.push_back('{kind, c, last});
        coefs_queued++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_coefs.size() > 0 || s_valid || expected_results.size() > 0);
    endtask

    task automatic write_frame_len(int v);
        wait_drained();
        repeat (tmpl_frames * (frame_len() + 3) + 10) @(negedge aclk);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_COEFS_PER_FRAME;
        pwdata <= APB_DATA_W'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cpf_reg = v & 63;
    endtask

    // frames complete frames, then extra coefficients of a broken frame
    task automatic send_template(int frames, int extra, bit noisy);
        int total;
        total = frames * frame_len() + extra;
        for (int i = 0; i < total; i++) begin
            if (noisy && $urandom_range(0, 5) == 0)
                pending_coefs.push_back('{KIND_SAMPLE, rand_coef(), 1'b0});
            push_coef(KIND_TEMPLATE, rand_coef(), i == total - 1);
        end
    endtask

    task automatic send_samples(int frames, int extra);
        int total;
        total = frames * frame_len() + extra;
        for (int i = 0; i < total; i++)
            push_coef(KIND_SAMPLE, rand_coef(), i == total - 1);
    endtask

    initial begin
        int n, tf, sf, p;
        int cpf_choices [8] = '{1, 2, 3, 4, 7, 32, 0, 63};
        bit ovf_done, hold_done;
        for (int i = 0; i < 4; i++) status_hits[i] = 0;
        ovf_done = 1'b0;
        hold_done = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, ignored sample, short and empty sequences
        pending_coefs.push_back('{KIND_SAMPLE, 16'h1234, 1'b1});
        push_coef(KIND_TEMPLATE, 16'h7fff, 1'b0);
        push_coef(KIND_TEMPLATE, 16'h8000, 1'b0);
        push_coef(KIND_TEMPLATE, 16'h0000, 1'b1);
        push_coef(KIND_SAMPLE, 16'h8000, 1'b0);
        push_coef(KIND_SAMPLE, 16'h7fff, 1'b0);
        push_coef(KIND_SAMPLE, 16'hffff, 1'b1);
        write_frame_len(2);
        send_template(2, 0, 1'b0);
        send_samples(1, 1);
        send_samples(2, 0);
        send_template(1, 1, 1'b0);
        send_samples(1, 0);
        send_template(0, 1, 1'b0);
        send_samples(1, 0);

        // random sequences
        while (coefs_queued < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 4) == 0) n = cpf_choices[$urandom_range(5, 7)];
                else n = cpf_choices[$urandom_range(0, 4)];
                write_frame_len(n);
            end
            n = frame_len();
            if (!ovf_done && coefs_queued > ITEM_TARGET / 3) begin
                write_frame_len(1);
                send_template(MAXF, 2, 1'b0);
                send_samples(2, 0);
                send_samples(1, 0);
                ovf_done = 1'b1;
                continue;
            end
            p = $urandom_range(0, 9);
            tf = $urandom_range(1, (64 / n < 8) ? ((64 / n < 1) ? 1 : 64 / n) : 8);
            send_template(tf, (p == 0) ? $urandom_range(1, n) - 1 : 0, p == 1);
            if (!hold_done && coefs_queued > ITEM_TARGET / 2) begin
                wait_drained();
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            repeat ($urandom_range(1, 3)) begin
                p = $urandom_range(0, 9);
                sf = $urandom_range(1, (96 / n < 6) ? ((96 / n < 1) ? 1 : 96 / n) : 6);
                if (p == 0) send_samples(0, (n > 1) ? $urandom_range(1, n - 1) : 1);
                else if (p == 1 && n > 1) send_samples(sf, $urandom_range(1, n - 1));
                else send_samples(sf, 0);
            end
        end

        wait_drained();
        repeat (tmpl_frames * (frame_len() + 3) + 20) @(negedge aclk);
        $display("covered %0d coefficient transfers, %0d results (ok %0d, short %0d, overflow %0d)",
                 coefs_taken, results_seen, status_hits[0], status_hits[1], status_hits[2]);
        $display("frame lengths 0..63 incl. extremes, full template overflow, long output stall");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/dtwl1_pkg.sv
hw/rtl/dtwl1_ctrl.sv
hw/rtl/dtwl1_datapath.sv
hw/rtl/dtw_l1_sequence_match.sv
tb/testbench.sv
